FILE: rtl/core/controller_report_send_gate_assert.svh
// assertion macros shared by the send gate rtl
// each macro samples on clk and is disabled while rst_n is low
`ifndef CONTROLLER_REPORT_SEND_GATE_ASSERT_SVH
`define CONTROLLER_REPORT_SEND_GATE_ASSERT_SVH

`ifndef SYNTHESIS
`define CRSG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRSG_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CRSG_ASSERT(label, prop, msg)
`define CRSG_ASSERT_NEVER(label, expr, msg)
`endif

`endif

FILE: rtl/core/crsg_pkg.sv
package crsg_pkg;

  localparam int unsigned TIME_W   = 48;
  localparam int unsigned TOUCH_W  = 40;
  localparam int unsigned STICK_W  = 16;
  localparam int unsigned TRIG_W   = 8;
  localparam int unsigned BTN_W    = 32;
  localparam int unsigned THRESH_W = 16;
  localparam int unsigned CAUSE_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned NUM_STICKS = 4;

  // result cause codes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE      = 3'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_THROTTLED = 3'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_FIRST     = 3'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_DISCRETE  = 3'd3;
  localparam logic [CAUSE_W-1:0] CAUSE_STICK     = 3'd4;
  localparam logic [CAUSE_W-1:0] CAUSE_INTERVAL  = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP         = 2'd2;

  localparam logic [THRESH_W-1:0] STICK_THRESHOLD_RST = 16'd512;
  localparam logic [TIME_W-1:0]   MOTION_INTERVAL_RST = 48'd8000000;
  localparam logic [TIME_W-1:0]   MIN_GAP_RST         = 48'd4000000;

  typedef struct packed {
    logic [BTN_W-1:0]                    buttons;
    logic [TRIG_W-1:0]                   left_trigger;
    logic [TRIG_W-1:0]                   right_trigger;
    logic [TOUCH_W-1:0]                  touch_zero;
    logic [TOUCH_W-1:0]                  touch_one;
    logic [NUM_STICKS-1:0][STICK_W-1:0]  sticks;
    logic [TIME_W-1:0]                   time_ns;
  } snap_t;

endpackage

FILE: rtl/core/crsg_if.sv
interface crsg_in_if import crsg_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [BTN_W-1:0]           buttons;
  logic [TRIG_W-1:0]          left_trigger;
  logic [TRIG_W-1:0]          right_trigger;
  logic [TOUCH_W-1:0]         touch_zero;
  logic [TOUCH_W-1:0]         touch_one;
  logic signed [STICK_W-1:0]  left_x;
  logic signed [STICK_W-1:0]  left_y;
  logic signed [STICK_W-1:0]  right_x;
  logic signed [STICK_W-1:0]  right_y;
  logic [TIME_W-1:0]          time_ns;

  modport source (
    output valid, buttons, left_trigger, right_trigger, touch_zero, touch_one,
           left_x, left_y, right_x, right_y, time_ns,
    input  ready
  );
  modport sink (
    input  valid, buttons, left_trigger, right_trigger, touch_zero, touch_one,
           left_x, left_y, right_x, right_y, time_ns,
    output ready
  );
endinterface

interface crsg_out_if import crsg_pkg::*;;
  logic               valid;
  logic               ready;
  logic               send;
  logic [CAUSE_W-1:0] cause;

  modport source (output valid, send, cause, input ready);
  modport sink (input valid, send, cause, output ready);
endinterface

FILE: rtl/core/controller_report_send_gate.sv
// controller report send gate
// in_chan carries one controller snapshot per transfer: buttons, both triggers,
// two packed touches, four stick axes and a 48-bit nanosecond timestamp.
// out_chan carries one result per snapshot: send and a 3-bit cause code.
// cfg_we/cfg_index/cfg_wdata write stick_threshold (0), motion_interval (1) and
// min_gap (2); an index past the list is ignored. write only while idle.
// a snapshot passes the input register, then the result register, to out_chan.
// throughput: one snapshot per cycle while out_chan does not stall; the
// decision for a snapshot reads the last-sent registers that the previous
// snapshot updated at the same edge it left the input register, so the
// compare-and-latch loop adds no stall.
// reset (synchronous, rst_n low) empties both stages, clears the last-sent
// snapshot, time and first-send flag, and loads register defaults.
// when out_chan stalls, the result holds; one more snapshot can sit in the
// input register, after which in_chan.ready drops until the result moves.
module controller_report_send_gate import crsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  crsg_in_if.sink               in_chan,
  crsg_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [THRESH_W-1:0] stick_threshold_r;
  logic [TIME_W-1:0]   motion_interval_r;
  logic [TIME_W-1:0]   min_gap_r;

  // last sent snapshot
  snap_t               sent_r;
  logic                have_sent_r;

  // input stage
  logic                s1_valid_r;
  snap_t               s1_item_r;

  // result stage
  logic                out_valid_r;
  logic                out_send_r;
  logic [CAUSE_W-1:0]  out_cause_r;

  logic                s1_adv;
  logic                in_ready;
  logic                in_xfer;
  snap_t               in_item;

  logic [TIME_W-1:0]   elapsed;
  logic                discrete;
  logic                moved;
  logic                due;
  logic                gap_ok;
  logic                send_c;
  logic [CAUSE_W-1:0]  cause_c;
  logic [NUM_STICKS-1:0] axis_moved;

  // handshake: the input stage moves on when the result register is free or
  // being drained this cycle
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_chan.valid && in_ready;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.send  = out_send_r;
  assign out_chan.cause = out_cause_r;

  assign in_item.buttons       = in_chan.buttons;
  assign in_item.left_trigger  = in_chan.left_trigger;
  assign in_item.right_trigger = in_chan.right_trigger;
  assign in_item.touch_zero    = in_chan.touch_zero;
  assign in_item.touch_one     = in_chan.touch_one;
  assign in_item.sticks        = {in_chan.right_y, in_chan.right_x,
                                  in_chan.left_y, in_chan.left_x};
  assign in_item.time_ns       = in_chan.time_ns;

  // time since last send, wraps mod 2^48 so a backward step reads as large
  assign elapsed = s1_item_r.time_ns - sent_r.time_ns;
  assign due     = elapsed >= motion_interval_r;
  assign gap_ok  = elapsed >= min_gap_r;

  // any change in the discrete fields goes out at once
  assign discrete = (s1_item_r.buttons       != sent_r.buttons)       ||
                    (s1_item_r.left_trigger  != sent_r.left_trigger)  ||
                    (s1_item_r.right_trigger != sent_r.right_trigger) ||
                    (s1_item_r.touch_zero    != sent_r.touch_zero)    ||
                    (s1_item_r.touch_one     != sent_r.touch_one);

  // per-axis movement at 17-bit signed precision
  always_comb begin
    logic signed [STICK_W:0] diff;
    logic [STICK_W:0]        mag;
    for (int i = 0; i < NUM_STICKS; i++) begin
      diff = $signed({s1_item_r.sticks[i][STICK_W-1], s1_item_r.sticks[i]})
           - $signed({sent_r.sticks[i][STICK_W-1], sent_r.sticks[i]});
      mag  = diff[STICK_W] ? (~diff + 1'b1) : diff;
      axis_moved[i] = mag > {1'b0, stick_threshold_r};
    end
  end
  assign moved = |axis_moved;

  // priority: first, discrete, then continuous sends gated by the minimum gap
  always_comb begin
    send_c  = 1'b0;
    cause_c = CAUSE_NONE;
    if (!have_sent_r) begin
      send_c  = 1'b1;
      cause_c = CAUSE_FIRST;
    end else if (discrete) begin
      send_c  = 1'b1;
      cause_c = CAUSE_DISCRETE;
    end else if (moved || due) begin
      if (!gap_ok) begin
        cause_c = CAUSE_THROTTLED;
      end else begin
        send_c  = 1'b1;
        cause_c = moved ? CAUSE_STICK : CAUSE_INTERVAL;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stick_threshold_r <= STICK_THRESHOLD_RST;
      motion_interval_r <= MOTION_INTERVAL_RST;
      min_gap_r         <= MIN_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STICK_THRESHOLD: stick_threshold_r <= cfg_wdata[THRESH_W-1:0];
        CFG_MOTION_INTERVAL: motion_interval_r <= cfg_wdata[TIME_W-1:0];
        CFG_MIN_GAP:         min_gap_r         <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_send_r  <= send_c;
      out_cause_r <= cause_c;
    end
  end

  // last-sent state, updated as the decision leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      have_sent_r <= 1'b0;
    end else if (s1_adv && send_c) begin
      sent_r      <= s1_item_r;
      have_sent_r <= 1'b1;
    end
  end

`include "controller_report_send_gate_assert.svh"

  `CRSG_ASSERT(a_send_matches_cause, out_valid_r |-> (out_send_r == (out_cause_r == CAUSE_FIRST || out_cause_r == CAUSE_DISCRETE || out_cause_r == CAUSE_STICK || out_cause_r == CAUSE_INTERVAL)), "send flag disagrees with cause")
  `CRSG_ASSERT_NEVER(a_have_sent_sticky, $fell(have_sent_r), "first-send flag cleared")
  `CRSG_ASSERT(a_time_latched, s1_adv && send_c |=> sent_r.time_ns == $past(s1_item_r.time_ns), "send time not latched")
  `CRSG_ASSERT(a_first_only_once, s1_adv && have_sent_r |-> cause_c != CAUSE_FIRST, "first cause after a send")
  `CRSG_ASSERT(a_full_stall_blocks, s1_valid_r && out_valid_r && !out_chan.ready |-> !in_chan.ready, "input taken while both stages full")

endmodule

FILE: test/tb_controller_report_send_gate.sv
`timescale 1ns / 1ps

module tb_controller_report_send_gate import crsg_pkg::*; ();

  // one verdict per snapshot, in transfer order
  typedef struct packed {
    logic               send;
    logic [CAUSE_W-1:0] cause;
  } verdict_t;

  // directed row: snapshot plus a hand-written verdict where typed is set
  typedef struct {
    snap_t    snap;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  // index past the register list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  crsg_in_if  snap_if ();
  crsg_out_if res_if ();

  controller_report_send_gate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (snap_if),
    .out_chan  (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // register copies as the block should hold them
  logic [THRESH_W-1:0] thresh_cfg;
  logic [TIME_W-1:0]   interval_cfg;
  logic [TIME_W-1:0]   gap_cfg;

  // last transmitted snapshot, time included, and the first-send flag
  snap_t last_sent;
  bit    have_sent;

  verdict_t    pending_verdicts[$];
  dir_row_t    dir_rows[$];
  int unsigned n_fail;
  bit          quiet;      // no idling on either side while set
  snap_t       walk;       // snapshot that the random walk moves around
  int unsigned walk_span;  // largest time step of the random walk
  verdict_t    head;

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_controller_report_send_gate: done, errors");
    $finish;
  end

  task automatic report_fail(input string what);
    n_fail++;
    $error("%s", what);
  endtask

  // sticks[0..3] carry left_x, left_y, right_x, right_y
  function automatic verdict_t predict_send(input snap_t s);
    verdict_t          v;
    logic [TIME_W-1:0] since;
    logic              moved;
    int                d;
    int                th;
    v.send  = 1'b0;
    v.cause = CAUSE_NONE;
    // elapsed time wraps at 48 bits, so a backwards stamp looks very old
    since = s.time_ns - last_sent.time_ns;
    th    = int'(thresh_cfg);
    if (!have_sent) begin
      // first snapshot goes out regardless of the gap
      v.send  = 1'b1;
      v.cause = CAUSE_FIRST;
    end else if (s.buttons != last_sent.buttons ||
                 s.left_trigger != last_sent.left_trigger ||
                 s.right_trigger != last_sent.right_trigger ||
                 s.touch_zero != last_sent.touch_zero ||
                 s.touch_one != last_sent.touch_one) begin
      // discrete change is never throttled
      v.send  = 1'b1;
      v.cause = CAUSE_DISCRETE;
    end else begin
      moved = 1'b0;
      for (int i = 0; i < NUM_STICKS; i++) begin
        // 17-bit signed difference, no overflow in an int
        d = int'($signed(s.sticks[i])) - int'($signed(last_sent.sticks[i]));
        if (d > th || d < -th) begin
          moved = 1'b1;
        end
      end
      if (moved || since >= interval_cfg) begin
        if (since < gap_cfg) begin
          v.cause = CAUSE_THROTTLED;
        end else begin
          v.send  = 1'b1;
          // stick movement wins over a due interval
          v.cause = moved ? CAUSE_STICK : CAUSE_INTERVAL;
        end
      end
    end
    if (v.send) begin
      last_sent = s;
      have_sent = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [TIME_W-1:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // drive one snapshot, called at a falling edge, returns at a falling edge
  task automatic send_snapshot(input snap_t s, input bit typed, input verdict_t want);
    verdict_t got;
    while (!quiet && $urandom_range(99) < 38) begin
      snap_if.valid = 1'b0;
      @(negedge clk);
    end
    snap_if.buttons       = s.buttons;
    snap_if.left_trigger  = s.left_trigger;
    snap_if.right_trigger = s.right_trigger;
    snap_if.touch_zero    = s.touch_zero;
    snap_if.touch_one     = s.touch_one;
    snap_if.left_x        = s.sticks[0];
    snap_if.left_y        = s.sticks[1];
    snap_if.right_x       = s.sticks[2];
    snap_if.right_y       = s.sticks[3];
    snap_if.time_ns       = s.time_ns;
    snap_if.valid         = 1'b1;
    do @(posedge clk); while (!snap_if.ready);
    // transfer taken at this edge, predictor runs on every one
    got = predict_send(s);
    pending_verdicts.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // wait until the block has handed back every result
  task automatic drain();
    snap_if.valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_STICK_THRESHOLD: thresh_cfg   = val[THRESH_W-1:0];
      CFG_MOTION_INTERVAL: interval_cfg = val[TIME_W-1:0];
      CFG_MIN_GAP:         gap_cfg      = val[TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic add_row(input logic [BTN_W-1:0] btn, input logic [TRIG_W-1:0] lt, rt,
                         input logic [TOUCH_W-1:0] tz, t1,
                         input logic [STICK_W-1:0] lx, ly, rx, ry,
                         input logic [TIME_W-1:0] t,
                         input bit typed, input logic send, input logic [CAUSE_W-1:0] cause);
    dir_row_t r;
    r.snap.buttons       = btn;
    r.snap.left_trigger  = lt;
    r.snap.right_trigger = rt;
    r.snap.touch_zero    = tz;
    r.snap.touch_one     = t1;
    r.snap.sticks[0]     = lx;
    r.snap.sticks[1]     = ly;
    r.snap.sticks[2]     = rx;
    r.snap.sticks[3]     = ry;
    r.snap.time_ns       = t;
    r.typed              = typed;
    r.want.send          = send;
    r.want.cause         = cause;
    dir_rows.push_back(r);
  endtask

  // next snapshot of the random walk: mostly a repeat of the last one with
  // a moving clock and small stick moves, plus some noise
  function automatic void step_walk();
    int unsigned       roll;
    int                v;
    int                th;
    logic [TIME_W-1:0] wide;
    th   = int'(thresh_cfg);
    roll = $urandom_range(99);
    if (roll < 4) begin
      walk.time_ns = rand48();
    end else if (roll < 7) begin
      // one tick behind the last send reads as the largest elapsed time
      walk.time_ns = last_sent.time_ns - 1;
    end else if (roll < 10) begin
      walk.time_ns = walk.time_ns - $urandom_range(0, walk_span);
    end else begin
      walk.time_ns = walk.time_ns + $urandom_range(0, walk_span);
    end
    roll = $urandom_range(99);
    if (roll < 4) begin
      walk.buttons = $urandom;
    end else if (roll < 8) begin
      walk.buttons[$urandom_range(BTN_W-1)] ^= 1'b1;
    end
    if ($urandom_range(99) < 4) walk.left_trigger  = TRIG_W'($urandom_range(255));
    if ($urandom_range(99) < 4) walk.right_trigger = TRIG_W'($urandom_range(255));
    roll = $urandom_range(99);
    wide = rand48();
    if (roll < 2) begin
      walk.touch_zero = wide[TOUCH_W-1:0];
    end else if (roll < 4) begin
      walk.touch_zero[$urandom_range(TOUCH_W-1)] ^= 1'b1;
    end
    roll = $urandom_range(99);
    wide = rand48();
    if (roll < 2) begin
      walk.touch_one = wide[TOUCH_W-1:0];
    end else if (roll < 4) begin
      walk.touch_one[$urandom_range(TOUCH_W-1)] ^= 1'b1;
    end
    for (int i = 0; i < NUM_STICKS; i++) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        // step around the threshold, clamped to the axis range
        v = int'($signed(walk.sticks[i])) + int'($urandom_range(0, 2 * th + 4)) - (th + 2);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        walk.sticks[i] = v[STICK_W-1:0];
      end else if (roll < 33) begin
        walk.sticks[i] = STICK_W'($urandom_range(16'hFFFF));
      end
    end
  endfunction

  task automatic run_phase(input logic [THRESH_W-1:0] th, input logic [TIME_W-1:0] iv, gap,
                           input int unsigned span, input int n, input bit no_idle);
    drain();
    write_cfg(CFG_STICK_THRESHOLD, {{(CFG_DATA_W-THRESH_W){1'b0}}, th});
    write_cfg(CFG_MOTION_INTERVAL, iv);
    write_cfg(CFG_MIN_GAP, gap);
    quiet     = no_idle;
    walk_span = span;
    repeat (n) begin
      step_walk();
      send_snapshot(walk, 1'b0, '0);
    end
    quiet = 1'b0;
  endtask

  // result side: ready changes at the falling edge, stalls at random
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready = quiet || ($urandom_range(99) >= 38);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        report_fail("result transfer with no snapshot pending");
      end else begin
        head = pending_verdicts.pop_front();
        if (res_if.send !== head.send) begin
          report_fail($sformatf("send: expected %0d, got %0d", head.send, res_if.send));
        end
        if (res_if.cause !== head.cause) begin
          report_fail($sformatf("cause: expected %0d, got %0d", head.cause, res_if.cause));
        end
      end
    end
  end

  initial begin
    logic [THRESH_W-1:0] th;
    logic [TIME_W-1:0]   iv;
    logic [TIME_W-1:0]   gap;
    n_fail       = 0;
    quiet        = 1'b0;
    have_sent    = 1'b0;
    last_sent    = '0;
    walk         = '0;
    walk_span    = 1000;
    thresh_cfg   = STICK_THRESHOLD_RST;
    interval_cfg = MOTION_INTERVAL_RST;
    gap_cfg      = MIN_GAP_RST;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_STICK_THRESHOLD;
    cfg_wdata = '0;
    snap_if.valid         = 1'b0;
    snap_if.buttons       = '0;
    snap_if.left_trigger  = '0;
    snap_if.right_trigger = '0;
    snap_if.touch_zero    = '0;
    snap_if.touch_one     = '0;
    snap_if.left_x        = '0;
    snap_if.left_y        = '0;
    snap_if.right_x       = '0;
    snap_if.right_y       = '0;
    snap_if.time_ns       = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part at reset settings: threshold 512, interval 8 ms, gap 4 ms
    // first snapshot at time zero, not throttled though the gap is not over
    add_row(32'h0, 8'h00, 8'h00, 40'h0, 40'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            48'd0, 1'b1, 1'b1, CAUSE_FIRST);
    add_row(32'h0, 8'h00, 8'h00, 40'h0, 40'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            48'd100, 1'b1, 1'b0, CAUSE_NONE);
    add_row(32'hFFFF_FFFF, 8'h00, 8'h00, 40'h0, 40'h0, 16'h0, 16'h0, 16'h0, 16'h0,
            48'd200, 1'b1, 1'b1, CAUSE_DISCRETE);
    // stick change equal to the threshold does not count
    add_row(32'hFFFF_FFFF, 8'h00, 8'h00, 40'h0, 40'h0, 16'd512, 16'h0, 16'h0, 16'h0,
            48'd300, 1'b1, 1'b0, CAUSE_NONE);
    add_row(32'hFFFF_FFFF, 8'h00, 8'h00, 40'h0, 40'h0, 16'd513, 16'h0, 16'h0, 16'h0,
            48'd400, 1'b1, 1'b0, CAUSE_THROTTLED);
    add_row(32'hFFFF_FFFF, 8'h00, 8'h00, 40'h0, 40'h0, 16'd513, 16'h0, 16'h0, 16'h0,
            48'd4_000_200, 1'b1, 1'b1, CAUSE_STICK);
    add_row(32'hFFFF_FFFF, 8'h00, 8'h00, 40'h0, 40'h0, 16'd513, 16'h0, 16'h0, 16'h0,
            48'd12_000_200, 1'b1, 1'b1, CAUSE_INTERVAL);
    // clock one tick backwards: elapsed time wraps to the maximum
    add_row(32'hFFFF_FFFF, 8'h00, 8'h00, 40'h0, 40'h0, 16'd513, 16'h0, 16'h0, 16'h0,
            48'd12_000_199, 1'b1, 1'b1, CAUSE_INTERVAL);
    // moved and interval due together report the stick
    add_row(32'hFFFF_FFFF, 8'h00, 8'h00, 40'h0, 40'h0, 16'h8000, 16'h0, 16'h0, 16'h0,
            48'd20_000_199, 1'b1, 1'b1, CAUSE_STICK);
    add_row(32'hFFFF_FFFF, 8'h00, 8'h00, 40'h0, 40'h0, 16'h8000, 16'h7FFF, 16'h0, 16'h0,
            48'd20_000_200, 1'b1, 1'b0, CAUSE_THROTTLED);
    add_row(32'hFFFF_FFFF, 8'hFF, 8'hFF, 40'h0, 40'h0, 16'h8000, 16'h7FFF, 16'h0, 16'h0,
            48'd20_000_300, 1'b1, 1'b1, CAUSE_DISCRETE);
    add_row(32'hFFFF_FFFF, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 40'h0,
            16'h8000, 16'h7FFF, 16'h0, 16'h0, 48'd20_000_400, 1'b1, 1'b1, CAUSE_DISCRETE);
    add_row(32'hFFFF_FFFF, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
            16'h8000, 16'h7FFF, 16'h0, 16'h0, 48'd20_000_500, 1'b1, 1'b1, CAUSE_DISCRETE);
    // largest timestamp, then wrap across zero
    add_row(32'hFFFF_FFFF, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
            16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1,
            CAUSE_STICK);
    add_row(32'hFFFF_FFFF, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
            16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 48'd7_999_998, 1'b1, 1'b0, CAUSE_NONE);
    add_row(32'hFFFF_FFFF, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
            16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 48'd7_999_999, 1'b1, 1'b1,
            CAUSE_INTERVAL);
    add_row(32'h0, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF,
            16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 48'd8_000_000, 1'b1, 1'b1,
            CAUSE_DISCRETE);
    // mixed patterns, checked by the predictor
    add_row(32'hAAAA_AAAA, 8'h55, 8'hAA, 40'hAA_AAAA_AAAA, 40'h55_5555_5555,
            16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 48'd8_000_100, 1'b0, 1'b0, CAUSE_NONE);
    add_row(32'h5555_5555, 8'hAA, 8'h55, 40'h55_5555_5555, 40'hAA_AAAA_AAAA,
            16'h1234, 16'hFEDC, 16'h0100, 16'hFF00, 48'd8_000_200, 1'b0, 1'b0, CAUSE_NONE);
    add_row(32'h5555_5555, 8'hAA, 8'h55, 40'h55_5555_5555, 40'hAA_AAAA_AAAA,
            16'h148C, 16'hFEDC, 16'h0100, 16'hFF00, 48'd8_000_300, 1'b0, 1'b0, CAUSE_NONE);
    add_row(32'h5555_5555, 8'hAA, 8'h55, 40'h55_5555_5555, 40'hAA_AAAA_AAAA,
            16'h148C, 16'hFEDC, 16'h0100, 16'hFF00, 48'd12_000_200, 1'b0, 1'b0, CAUSE_NONE);

    foreach (dir_rows[i]) begin
      send_snapshot(dir_rows[i].snap, dir_rows[i].typed, dir_rows[i].want);
    end
    walk = dir_rows[dir_rows.size()-1].snap;

    // a write past the register list must change nothing
    drain();
    write_cfg(CFG_UNUSED, {CFG_DATA_W{1'b1}});

    // zero threshold, zero interval, zero gap: every snapshot goes out
    run_phase(16'd0, 48'd0, 48'd0, 50, 200, 1'b0);
    // all registers at their maximum: nothing moves, interval only on the
    // largest elapsed time
    run_phase(16'hFFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 150, 1'b0);
    // reset values again, long run with both sides never idle
    run_phase(STICK_THRESHOLD_RST, MOTION_INTERVAL_RST, MIN_GAP_RST, 3_000_000, 300, 1'b1);
    // random settings on a small time scale
    repeat (4) begin
      th  = THRESH_W'($urandom_range(0, 3000));
      iv  = TIME_W'($urandom_range(0, 20000));
      gap = TIME_W'($urandom_range(0, 20000));
      run_phase(th, iv, gap, 32'(((iv > gap) ? iv : gap) / 3 + 1), 190, 1'b0);
    end

    drain();
    repeat (8) @(posedge clk);
    if (n_fail == 0 && pending_verdicts.size() == 0) begin
      $display("tb_controller_report_send_gate: done, clean");
    end else begin
      $display("tb_controller_report_send_gate: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/crsg_pkg.sv
rtl/core/crsg_if.sv
rtl/core/controller_report_send_gate.sv
test/tb_controller_report_send_gate.sv
